FILE: sv/psu_pkg.sv
// shared types, codes and the paeth predictor for the png scanline unfilter
`timescale 1ns / 1ps

package psu_pkg;

  // configuration register widths and indexes
  localparam int BPP_W = 4;
  localparam int ROW_BYTES_W = 14;
  localparam int CFG_DATA_W = 14;
  localparam logic CFG_BPP = 1'b0;
  localparam logic CFG_ROW_BYTES = 1'b1;

  // row filter kinds as carried in the filter byte
  typedef enum logic [2:0] {
    FLT_NONE  = 3'd0,
    FLT_SUB   = 3'd1,
    FLT_UP    = 3'd2,
    FLT_AVG   = 3'd3,
    FLT_PAETH = 3'd4,
    FLT_BAD   = 3'd7
  } filt_kind_t;

  // status of the slot remainder unit
  typedef struct packed {
    logic       busy;
    logic       done;
    logic [2:0] rem;
  } div_stat_t;

  // paeth predictor, distances at full precision
  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic signed [10:0] sa;
    logic signed [10:0] sb;
    logic signed [10:0] sc;
    logic signed [10:0] da;
    logic signed [10:0] db;
    logic signed [10:0] dc;
    logic [9:0] pa;
    logic [9:0] pb;
    logic [9:0] pc;
    logic [7:0] res;
    sa = signed'({3'b000, a});
    sb = signed'({3'b000, b});
    sc = signed'({3'b000, c});
    da = sb - sc;
    db = sa - sc;
    dc = sa + sb - (sc <<< 1);
    pa = da[10] ? 10'(-da) : da[9:0];
    pb = db[10] ? 10'(-db) : db[9:0];
    pc = dc[10] ? 10'(-dc) : dc[9:0];
    if (pa <= pb && pa <= pc) begin
      res = a;
    end else if (pb <= pc) begin
      res = b;
    end else begin
      res = c;
    end
    return res;
  endfunction

endpackage

FILE: sv/psu_if.sv
// valid/ready stream interfaces for filtered input bytes and reconstructed bytes
`timescale 1ns / 1ps

interface psu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       image_start;

  modport source (output valid, output data_byte, output image_start, input ready);
  modport sink (input valid, input data_byte, input image_start, output ready);
endinterface

interface psu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;
  logic       row_end;
  logic       bad_filter;

  modport source (output valid, output pixel_byte, output row_end, output bad_filter,
                  input ready);
  modport sink (input valid, input pixel_byte, input row_end, input bad_filter,
                output ready);
endinterface

FILE: sv/psu_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module psu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/psu_slot_div.sv
// bit serial remainder of the column position by bytes per pixel
`timescale 1ns / 1ps

module psu_slot_div #(
  parameter int AW = 13
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start_i,
  input  logic [AW-1:0]                dividend_i,
  input  logic [psu_pkg::BPP_W-1:0]    divisor_i,
  output psu_pkg::div_stat_t           stat_o
);

  localparam int CNT_W = $clog2(AW + 1);

  logic [AW-1:0]    sh_r;
  logic [2:0]       rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic [3:0]       trial;
  logic [2:0]       rem_nxt;

  // one restoring step per cycle, msb first
  always_comb begin
    trial = {rem_r, sh_r[AW-1]};
    if (trial >= divisor_i) begin
      rem_nxt = 3'(trial - divisor_i);
    end else begin
      rem_nxt = trial[2:0];
    end
  end

  // control count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start_i) begin
      cnt_r <= CNT_W'(AW);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // operand shift and partial remainder
  always_ff @(posedge clk) begin
    if (start_i) begin
      sh_r  <= dividend_i;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      sh_r  <= sh_r << 1;
      rem_r <= rem_nxt;
    end
  end

  // status out, rem is final in the done cycle
  always_comb begin
    stat_o.busy = start_i || (cnt_r != '0);
    stat_o.done = !start_i && (cnt_r == CNT_W'(1));
    stat_o.rem  = rem_nxt;
  end

endmodule

FILE: sv/png_scanline_unfilter_unit.sv
// png scanline filter reconstruction, one byte per cycle
//
//   port      dir  payload                               transfer
//   in_chan   in   data_byte[7:0] image_start            valid & ready
//   out_chan  out  pixel_byte[7:0] row_end bad_filter    valid & ready
//   cfg_*     in   cfg_index cfg_wdata[13:0]             cfg_we
//
// One input byte is taken per cycle; a filter byte gives no result, a data byte gives one
// result in the output register on the following cycle. The output register frees in the
// same cycle it is taken, so bytes flow back to back; a stall on out_chan holds in_chan.
// Each config write holds off input while the pixel slot is recomputed by the bit serial
// remainder unit and the line store read refreshes. Reset is synchronous; the line store is
// not cleared and holds nothing meaningful until its first row is written.
`timescale 1ns / 1ps

module png_scanline_unfilter_unit #(
  parameter int MAX_ROW_BYTES = 8192,
  parameter int MAX_PIXEL_BYTES = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  psu_in_if.sink                         in_chan,
  psu_out_if.source                      out_chan,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [psu_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW  = $clog2(MAX_ROW_BYTES);
  localparam int RBW = $clog2(MAX_ROW_BYTES + 1);
  localparam int CW  = (RBW > psu_pkg::ROW_BYTES_W) ? RBW : psu_pkg::ROW_BYTES_W;
  localparam int SW  = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
  localparam int HW  = AW + psu_pkg::BPP_W;

  // config registers
  logic [psu_pkg::BPP_W-1:0]       bpp_r;
  logic [psu_pkg::ROW_BYTES_W-1:0] rb_r;
  logic                            cfg_wr_r;

  // row state
  logic [AW-1:0]        col_r;
  logic [SW-1:0]        slot_r;
  psu_pkg::filt_kind_t  kind_r;
  logic                 await_r;
  logic                 first_row_r;
  logic [7:0]           left_r [MAX_PIXEL_BYTES];
  logic [7:0]           upleft_r [MAX_PIXEL_BYTES];

  // output register
  logic       out_valid_r;
  logic [7:0] pixel_r;
  logic       row_end_r;
  logic       bad_r;

  // datapath signals
  logic [psu_pkg::BPP_W-1:0] bpp_eff;
  logic [CW-1:0]             rb_ext;
  logic [RBW-1:0]            rb_eff;
  logic [AW-1:0]             col_eff;
  logic [AW-1:0]             col_nxt;
  logic [AW-1:0]             rd_addr;
  logic                      have_left;
  logic                      last;
  logic [7:0]                mem_rdata;
  logic [7:0]                a_val;
  logic [7:0]                b_val;
  logic [7:0]                c_val;
  logic [7:0]                pred;
  logic [8:0]                avg_sum;
  logic                      bad;
  logic [7:0]                recon;
  logic                      accept;
  logic                      is_filter;
  logic                      filt_acc;
  logic                      data_acc;
  logic [SW-1:0]             slot_inc;
  psu_pkg::div_stat_t        div_stat;

  // clamp config into legal range
  always_comb begin
    if (bpp_r == '0) begin
      bpp_eff = psu_pkg::BPP_W'(1);
    end else if (bpp_r > psu_pkg::BPP_W'(MAX_PIXEL_BYTES)) begin
      bpp_eff = psu_pkg::BPP_W'(MAX_PIXEL_BYTES);
    end else begin
      bpp_eff = bpp_r;
    end
    rb_ext = CW'(rb_r);
    if (rb_ext == '0) begin
      rb_eff = RBW'(1);
    end else if (rb_ext > CW'(MAX_ROW_BYTES)) begin
      rb_eff = RBW'(MAX_ROW_BYTES);
    end else begin
      rb_eff = rb_ext[RBW-1:0];
    end
  end

  // column position, edge flags and neighbours
  always_comb begin
    if (RBW'(col_r) >= rb_eff) begin
      col_eff = AW'(rb_eff - 1'b1);
    end else begin
      col_eff = col_r;
    end
    have_left = HW'(col_eff) >= HW'(bpp_eff);
    last      = (RBW'(col_eff) + 1'b1) >= rb_eff;
    a_val     = have_left ? left_r[slot_r] : 8'd0;
    b_val     = first_row_r ? 8'd0 : mem_rdata;
    c_val     = (have_left && !first_row_r) ? upleft_r[slot_r] : 8'd0;
  end

  // predictor select and reconstruction
  always_comb begin
    avg_sum = {1'b0, a_val} + {1'b0, b_val};
    unique case (kind_r)
      psu_pkg::FLT_NONE:  pred = 8'd0;
      psu_pkg::FLT_SUB:   pred = a_val;
      psu_pkg::FLT_UP:    pred = b_val;
      psu_pkg::FLT_AVG:   pred = avg_sum[8:1];
      psu_pkg::FLT_PAETH: pred = psu_pkg::paeth(a_val, b_val, c_val);
      default:            pred = 8'd0;
    endcase
    bad   = kind_r > psu_pkg::FLT_PAETH;
    recon = bad ? 8'd0 : 8'(in_chan.data_byte + pred);
  end

  // handshake
  always_comb begin
    in_chan.ready = !div_stat.busy && !cfg_we && (!out_valid_r || out_chan.ready);
    accept        = in_chan.valid && in_chan.ready;
    is_filter     = in_chan.image_start || await_r;
    filt_acc      = accept && is_filter;
    data_acc      = accept && !is_filter;
  end

  // next column and line store read address
  always_comb begin
    if (filt_acc || (data_acc && last)) begin
      col_nxt = '0;
    end else if (data_acc) begin
      col_nxt = col_eff + 1'b1;
    end else begin
      col_nxt = col_r;
    end
    if (RBW'(col_nxt) >= rb_eff) begin
      rd_addr = AW'(rb_eff - 1'b1);
    end else begin
      rd_addr = col_nxt;
    end
    if ((psu_pkg::BPP_W'(slot_r) + 1'b1) == bpp_eff) begin
      slot_inc = '0;
    end else begin
      slot_inc = slot_r + 1'b1;
    end
  end

  // config write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r    <= psu_pkg::BPP_W'(1);
      rb_r     <= psu_pkg::ROW_BYTES_W'(1);
      cfg_wr_r <= 1'b0;
    end else begin
      cfg_wr_r <= cfg_we;
      if (cfg_we) begin
        unique case (cfg_index)
          psu_pkg::CFG_BPP:       bpp_r <= cfg_wdata[psu_pkg::BPP_W-1:0];
          psu_pkg::CFG_ROW_BYTES: rb_r  <= cfg_wdata[psu_pkg::ROW_BYTES_W-1:0];
          default:                rb_r  <= rb_r;
        endcase
      end
    end
  end

  // row control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      slot_r      <= '0;
      kind_r      <= psu_pkg::FLT_NONE;
      await_r     <= 1'b1;
      first_row_r <= 1'b1;
    end else begin
      col_r <= col_nxt;
      if (div_stat.done) begin
        slot_r <= SW'(div_stat.rem);
      end else if (filt_acc || (data_acc && last)) begin
        slot_r <= '0;
      end else if (data_acc) begin
        slot_r <= slot_inc;
      end
      if (filt_acc) begin
        if (in_chan.data_byte <= 8'd4) begin
          kind_r <= psu_pkg::filt_kind_t'(in_chan.data_byte[2:0]);
        end else begin
          kind_r <= psu_pkg::FLT_BAD;
        end
        await_r <= 1'b0;
        if (in_chan.image_start) begin
          first_row_r <= 1'b1;
        end
      end else if (data_acc && last) begin
        await_r     <= 1'b1;
        first_row_r <= 1'b0;
      end
    end
  end

  // pixel windows for left and up-left neighbours
  always_ff @(posedge clk) begin
    if (!rst_n || filt_acc) begin
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        left_r[i]   <= 8'd0;
        upleft_r[i] <= 8'd0;
      end
    end else if (data_acc) begin
      left_r[slot_r]   <= recon;
      upleft_r[slot_r] <= b_val;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (data_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (data_acc) begin
      pixel_r   <= recon;
      row_end_r <= last;
      bad_r     <= bad;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.pixel_byte = pixel_r;
  assign out_chan.row_end    = row_end_r;
  assign out_chan.bad_filter = bad_r;

  // previous row line store
  psu_ram #(
    .WIDTH(8),
    .DEPTH(MAX_ROW_BYTES)
  ) u_line (
    .clk  (clk),
    .we   (data_acc),
    .waddr(col_eff),
    .wdata(recon),
    .raddr(rd_addr),
    .rdata(mem_rdata)
  );

  // slot recompute after config writes
  psu_slot_div #(
    .AW(AW)
  ) u_slot_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start_i   (cfg_wr_r),
    .dividend_i(col_eff),
    .divisor_i (bpp_eff),
    .stat_o    (div_stat)
  );

  // checks
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    data_acc && bad |=> out_chan.valid && out_chan.bad_filter && (out_chan.pixel_byte == 8'd0))
    else $error("bad filter row gave nonzero pixel");

  a_row_end_await: assert property (@(posedge clk) disable iff (!rst_n)
    data_acc && last |=> await_r && (col_r == '0))
    else $error("row end did not rearm filter byte");

  a_cfg_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !(in_chan.valid && in_chan.ready))
    else $error("input taken right after config write");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    data_acc |-> (psu_pkg::BPP_W'(slot_r) < bpp_eff))
    else $error("pixel slot beyond bytes per pixel");

endmodule
